FILE: rtl/boundary_tag_next_fit_allocator_defines.svh
// Assertion macros shared by the allocator checker.
// No dependencies.
`ifndef BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_DEFINES_SVH
// implication checked every clock, off during reset
`define BTA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/bta_pkg.sv
// Package for the boundary-tag allocator: widths, word layout, reset values.
// No dependencies.
`timescale 1ns / 1ps
package bta_pkg;
  localparam int POOL_WORDS_DEF = 1024;
  localparam int FW = 11;
  localparam logic [FW-1:0] MIN_REM_RESET = 11'd10;
  typedef struct packed {
    logic [FW-1:0] link;
    logic          tag;
    logic [FW-1:0] size;
    logic [FW-1:0] rlink;
  } word_t;
endpackage

FILE: rtl/bta_if.sv
// Valid/ready channel interface, payload width set by parameter.
// Depends on nothing.
`timescale 1ns / 1ps
interface bta_if #(parameter int W = 11);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bta_res_if.sv
// Result channel interface: granted, block_address, block_size.
// Depends on nothing.
`timescale 1ns / 1ps
interface bta_res_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [10:0] block_address;
  logic [10:0] block_size;
  modport source (output valid, output granted, output block_address,
                  output block_size, input ready);
  modport sink (input valid, input granted, input block_address,
                input block_size, output ready);
endinterface

FILE: rtl/boundary_tag_next_fit_allocator.sv
// Boundary-tag next-fit allocator top level.
// Depends on bta_pkg, bta_if, bta_res_if, bta_store.
// Usage:
//   req (sink): one word per request, data = request_size.
//   cfg (sink): one word writes min_remainder; taken only while idle or clearing.
//   res (source): one word per request: granted, block_address, block_size.
// Sequence from acceptance to result valid:
//   zero request or empty list: the result is registered directly from idle.
//   walk: per visited block a read-address state, then registered read data;
//   no fit ends with a failed result. Grant: four read-modify-write updates
//   follow, each a read state then a write state; two when the last free
//   block goes whole. All of it is set by the single read port.
// The next request is taken only after the result leaves and the allocator
//   is back in idle; requests do not overlap.
// Reset: rst (sync) starts a clearing pass over all POOL_WORDS+2 words that writes
//   the pool as one free block with tagged boundary words; requests wait.
// Stall: the result is held in an output register until taken.
// Indexes out of the store are clamped to the last word. Word indexes are
//   11 bits wide as in the word layout.
`timescale 1ns / 1ps
module boundary_tag_next_fit_allocator #(
  parameter int POOL_WORDS = bta_pkg::POOL_WORDS_DEF
) (
  input logic clk,
  input logic rst,
  bta_if.sink     req,
  bta_if.sink     cfg,
  bta_res_if.source res
);
  localparam int DEPTH = POOL_WORDS + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int FW = bta_pkg::FW;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_UPD_RD, S_UPD_WR, S_OUT
  } state_t;
  state_t state;

  logic [FW-1:0] min_rem, n, rover, start, p, succ, left_i, f_old, f_new, blk_size;
  logic [FW-1:0] q, nxt, rem, upd_addr;
  logic list_empty, whole;
  logic [AW:0] steps;
  logic [AW-1:0] init_cnt;
  logic [1:0] upd;
  bta_pkg::word_t rdata, init_word, upd_word;

  logic we;
  logic [AW-1:0] waddr, raddr;
  bta_pkg::word_t wdata;

  // clamp a 12-bit index into the store
  function automatic logic [FW-1:0] clampi(input logic [FW:0] x);
    if (x < (FW+1)'(DEPTH)) return x[FW-1:0];
    return FW'(DEPTH - 1);
  endfunction

  bta_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  // config has priority over a request in the same idle cycle
  assign cfg.ready = !rst && (state == S_IDLE || state == S_INIT);
  assign req.ready = !rst && (state == S_IDLE) && !cfg.valid;

  assign nxt = clampi({1'b0, rdata.rlink});
  assign rem = rdata.size - n;
  // head of the cut-off block sits right above the new foot
  assign q = clampi({1'b0, f_new} + (FW+1)'(1));

  // pool image written by the clearing pass
  always_comb begin
    init_word = '0;
    if (init_cnt == '0 || init_cnt == LAST) begin
      init_word.tag = 1'b1;
    end else if (init_cnt == AW'(1)) begin
      init_word.link = FW'(1); init_word.rlink = FW'(1); init_word.size = FW'(POOL_WORDS);
    end else if (init_cnt == AW'(POOL_WORDS)) begin
      init_word.link = FW'(1);
    end
  end

  // update steps, in order:
  //   whole: succ.link, left.rlink, head tag, foot tag
  //   split: old foot tag, head size, new foot, new head
  always_comb begin
    upd_addr = p;
    case (upd)
      2'd0: upd_addr = whole ? succ : f_old;
      2'd1: upd_addr = whole ? left_i : p;
      2'd2: upd_addr = whole ? p : f_new;
      2'd3: upd_addr = whole ? f_old : q;
      default: upd_addr = p;
    endcase
  end

  always_comb begin
    upd_word = rdata;
    case (upd)
      2'd0: begin
        if (whole) upd_word.link = left_i;
        else upd_word.tag = 1'b1;
      end
      2'd1: begin
        if (whole) upd_word.rlink = succ;
        else upd_word.size = rdata.size - n;
      end
      2'd2: begin
        if (whole) begin
          upd_word.tag = 1'b1;
        end else begin
          // new foot of the remainder: tag cleared, link back to its head
          upd_word.tag = 1'b0; upd_word.link = p;
        end
      end
      2'd3: begin
        upd_word.tag = 1'b1;
        if (!whole) upd_word.size = n;
      end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    we = 1'b0; waddr = init_cnt; wdata = init_word;
    raddr = AW'(p);
    case (state)
      S_INIT: we = 1'b1;
      S_UPD_RD: raddr = AW'(upd_addr);
      S_UPD_WR: begin
        we = 1'b1; waddr = AW'(upd_addr); wdata = upd_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_cnt <= '0; rover <= FW'(1); list_empty <= 1'b0;
      res.valid <= 1'b0; min_rem <= bta_pkg::MIN_REM_RESET;
    end else begin
      if (cfg.valid && cfg.ready) min_rem <= cfg.data;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + AW'(1);
          if (init_cnt == LAST) state <= S_IDLE;
        end
        S_IDLE: if (req.valid && req.ready) begin
          n <= req.data;
          if (req.data == '0 || list_empty) begin
            res.granted <= 1'b0; res.block_address <= '0; res.block_size <= '0;
            res.valid <= 1'b1; state <= S_OUT;
          end else begin
            start <= clampi({1'b0, rover}); p <= clampi({1'b0, rover});
            steps <= '0; state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (rdata.size >= n) begin
            succ <= nxt; rover <= nxt;
            left_i <= clampi({1'b0, rdata.link});
            blk_size <= rdata.size;
            whole <= (rem <= min_rem);
            f_old <= clampi({1'b0, p} + {1'b0, rdata.size} - (FW+1)'(1));
            f_new <= clampi({1'b0, p} + {1'b0, rem} - (FW+1)'(1));
            // last free block taken whole: no neighbors to relink
            if (rem <= min_rem && nxt == p) begin
              list_empty <= 1'b1; upd <= 2'd2;
            end else begin
              upd <= 2'd0;
            end
            state <= S_UPD_RD;
          end else if (nxt != start && steps < (AW+1)'(DEPTH)) begin
            p <= nxt; steps <= steps + (AW+1)'(1); state <= S_RD;
          end else begin
            res.granted <= 1'b0; res.block_address <= '0; res.block_size <= '0;
            res.valid <= 1'b1; state <= S_OUT;
          end
        end
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: begin
          if (upd == 2'd3) begin
            res.granted <= 1'b1;
            res.block_address <= whole ? p : q;
            res.block_size <= whole ? blk_size : n;
            res.valid <= 1'b1; state <= S_OUT;
          end else begin
            upd <= upd + 2'd1; state <= S_UPD_RD;
          end
        end
        S_OUT: if (res.ready) begin
          res.valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/bta_store.sv
// Word store: one write port, one read port, registered read data.
// Depends on bta_pkg.
`timescale 1ns / 1ps
module bta_store #(
  parameter int DEPTH = bta_pkg::POOL_WORDS_DEF + 2,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  bta_pkg::word_t wdata,
  input  logic [AW-1:0]  raddr,
  output bta_pkg::word_t rdata
);
  bta_pkg::word_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/bta_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on the defines header.
`timescale 1ns / 1ps
`include "boundary_tag_next_fit_allocator_defines.svh"
module bta_checker (
  input logic clk, input logic rst,
  input logic req_valid, input logic req_ready,
  input logic res_valid, input logic res_ready,
  input logic granted, input logic [10:0] block_address, input logic [10:0] block_size
);
  `BTA_ASSERT_IMPL(a_fail_zero, clk, rst, res_valid && !granted, block_address == 11'd0 && block_size == 11'd0, "failed result not zero")
  `BTA_ASSERT_IMPL(a_grant_size, clk, rst, res_valid && granted, block_size != 11'd0, "grant of zero words")
  `BTA_ASSERT_IMPL(a_one_at_time, clk, rst, res_valid, !req_ready, "request taken while result pending")
  `BTA_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(block_address), "result dropped")
endmodule
bind boundary_tag_next_fit_allocator bta_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .granted(res.granted),
  .block_address(res.block_address), .block_size(res.block_size));
